FILE: src/fpwc_pkg.sv
// Package for the fractional-N PLL word calculator: widths, band table, pipeline types.
package fpwc_pkg;

    // Field and datapath widths.
    localparam int FREQ_W    = 31;
    localparam int CRYSTAL_W = 25;
    localparam int PFD_W     = 24;
    localparam int FRAC_W    = 19;
    localparam int QUOT_W    = FREQ_W + FRAC_W;
    localparam int CODE_W    = 3;
    localparam int ODIV_W    = 5;
    localparam int IWORD_W   = 8;
    localparam int FWORD_W   = 20;

    // Long division layout: quotient bits resolved per stage and stage count.
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = QUOT_W / STEPS_PER_STAGE;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int LATENCY = DIV_STAGES + 3;

    localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET = 25'd30000000;

    // Multiply-and-shift reciprocal of three, exact for any 32-bit operand.
    localparam logic [31:0] RECIP_THIRD = 32'hAAAAAAAB;
    localparam int          THIRD_SHIFT = 33;
    localparam int          PROD_W      = CRYSTAL_W + 32;

    // Integer word limits.
    localparam logic [FREQ_W-1:0]  QUOT_SAT  = 31'd256;
    localparam logic [IWORD_W-1:0] IWORD_MAX = 8'd255;

    // Supported bands, named after their output divider.
    typedef enum logic [1:0] {
        BAND_DIV4  = 2'd0,
        BAND_DIV8  = 2'd1,
        BAND_DIV12 = 2'd2,
        BAND_DIV24 = 2'd3
    } band_t;

    localparam int NUM_BANDS = 4;

    localparam logic [FREQ_W-1:0] BAND_LO [NUM_BANDS] = '{
        31'd850000000, 31'd425000000, 31'd284000000, 31'd142000000
    };
    localparam logic [FREQ_W-1:0] BAND_HI [NUM_BANDS] = '{
        31'd1050000000, 31'd525000000, 31'd350000000, 31'd175000000
    };
    localparam logic [CODE_W-1:0] BAND_CODE [NUM_BANDS] = '{
        3'd0, 3'd2, 3'd3, 3'd5
    };
    localparam logic [ODIV_W-1:0] BAND_ODIV [NUM_BANDS] = '{
        5'd4, 5'd8, 5'd12, 5'd24
    };

    // Partial remainder, dividend shifting into quotient, and divisor.
    typedef struct packed {
        logic [PFD_W-1:0]  rem;
        logic [QUOT_W-1:0] num;
        logic [PFD_W-1:0]  pfd;
    } div_t;

    // Band information that travels alongside the division.
    typedef struct packed {
        logic              status;
        logic [CODE_W-1:0] band_code;
        logic [ODIV_W-1:0] out_div;
        logic              pfd_zero;
    } side_t;

    // One restoring long-division step: bring in the next dividend bit,
    // subtract the divisor when it fits and shift in the quotient bit.
    function automatic div_t div_step(input div_t d);
        logic [PFD_W:0] trial;
        div_t           r;
        r     = d;
        trial = {d.rem, d.num[QUOT_W-1]};
        if (trial >= {1'b0, d.pfd})
        begin
            r.rem = PFD_W'(trial - {1'b0, d.pfd});
            r.num = {d.num[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[PFD_W-1:0];
            r.num = {d.num[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: src/fractional_pll_word_calc.sv
// Top level of the fractional-N PLL word calculator: band select, PFD and pipelined divider.
//
// Usage: a request is a transaction on start/frequency_hz, taken at a rising edge at which
// start is high and busy is low. busy stays low, so a new frequency may be given every
// cycle. Each request gives one result on status, band_code, output_divider,
// pll_integer_word and pll_fraction_word, shown for exactly one cycle with done high.
// A result passes through stage A, for band select and the crystal-over-three product,
// stage B, for the phase detector frequency, 25 divider stages of two quotient bits each
// for the 50-bit long division of frequency_hz * 2^19 by f_pfd, and one output register.
// Throughput is one result per cycle, set by the fully pipelined divider.
// The crystal frequency is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high, and the register must only be written while no request is in flight.
// Reset clears all valid bits, so no result appears until a request is taken, and sets
// the crystal frequency to 30 MHz. The receiver cannot stall; results are never held.
module fractional_pll_word_calc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fpwc_pkg::FREQ_W-1:0]       frequency_hz,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpwc_pkg::CRYSTAL_W-1:0]    cfg_data,
    output logic                              done,
    output logic                              status,
    output logic [fpwc_pkg::CODE_W-1:0]       band_code,
    output logic [fpwc_pkg::ODIV_W-1:0]       output_divider,
    output logic [fpwc_pkg::IWORD_W-1:0]      pll_integer_word,
    output logic [fpwc_pkg::FWORD_W-1:0]      pll_fraction_word
);
    import fpwc_pkg::*;

    logic                 accept;
    logic [CRYSTAL_W-1:0] crystal_reg;

    // Stage A: band select and crystal / 3.
    logic                 a_vld_reg;
    logic [FREQ_W-1:0]    a_freq_reg;
    band_t                a_band_reg;
    band_t                band_next;
    logic                 a_inband_reg;
    logic                 inband_next;
    logic [PFD_W-1:0]     a_third_reg;
    logic [PROD_W-1:0]    third_prod;

    // Stage B and divider pipeline.
    logic [PFD_W-1:0]     pfd_next;
    logic                 vld_reg  [0:DIV_STAGES];
    div_t                 div_reg  [0:DIV_STAGES];
    side_t                side_reg [0:DIV_STAGES];

    // Output stage.
    logic [FREQ_W-1:0]    quot_int;
    logic [IWORD_W-1:0]   iword_next;
    logic [FWORD_W-1:0]   fword_next;
    logic                 done_reg;
    logic                 status_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [ODIV_W-1:0]    odiv_reg;
    logic [IWORD_W-1:0]   iword_reg;
    logic [FWORD_W-1:0]   fword_reg;

    // The pipeline never stalls, so requests and writes are always taken.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Crystal frequency register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crystal_reg <= CRYSTAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            crystal_reg <= cfg_data;
        end
    end

    // Band match; the bands do not overlap, so the lowest matching entry wins.
    always_comb
    begin
        band_next   = BAND_DIV4;
        inband_next = 1'b0;
        for (int b = NUM_BANDS - 1; b >= 0; b--)
        begin
            if (frequency_hz >= BAND_LO[b] && frequency_hz <= BAND_HI[b])
            begin
                band_next   = band_t'(b);
                inband_next = 1'b1;
            end
        end
    end

    // Crystal divided by three through a reciprocal product.
    assign third_prod = PROD_W'(crystal_reg) * PROD_W'(RECIP_THIRD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        a_freq_reg   <= frequency_hz;
        a_band_reg   <= band_next;
        a_inband_reg <= inband_next;
        a_third_reg  <= third_prod[THIRD_SHIFT +: PFD_W];
    end

    // Phase detector frequency: 2 * crystal over the output divider.
    always_comb
    begin
        case (a_band_reg)
            BAND_DIV4:  pfd_next = crystal_reg[CRYSTAL_W-1:1];
            BAND_DIV8:  pfd_next = PFD_W'(crystal_reg[CRYSTAL_W-1:2]);
            BAND_DIV12: pfd_next = {1'b0, a_third_reg[PFD_W-1:1]};
            BAND_DIV24: pfd_next = {2'b00, a_third_reg[PFD_W-1:2]};
            default:    pfd_next = '0;
        endcase
    end

    // Stage B: load the divider with frequency * 2^19 over f_pfd.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg[0].rem          <= '0;
        div_reg[0].num          <= {a_freq_reg, {FRAC_W{1'b0}}};
        div_reg[0].pfd          <= pfd_next;
        side_reg[0].status      <= !a_inband_reg;
        side_reg[0].band_code   <= BAND_CODE[a_band_reg];
        side_reg[0].out_div     <= BAND_ODIV[a_band_reg];
        side_reg[0].pfd_zero    <= (pfd_next == '0);
    end

    // Divider stages, each resolving a fixed number of quotient bits.
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        div_t stage_next;

        always_comb
        begin
            stage_next = div_reg[i];
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                stage_next = div_step(stage_next);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[i+1]  <= stage_next;
            side_reg[i+1] <= side_reg[i];
        end
    end

    // Integer word with its clamps, and the fraction with its leading one.
    assign quot_int = div_reg[DIV_STAGES].num[QUOT_W-1:FRAC_W];

    always_comb
    begin
        if (side_reg[DIV_STAGES].pfd_zero)
        begin
            iword_next = IWORD_MAX;
            fword_next = '0;
        end
        else
        begin
            if (quot_int == '0)
            begin
                iword_next = '0;
            end
            else if (quot_int > QUOT_SAT)
            begin
                iword_next = IWORD_MAX;
            end
            else
            begin
                iword_next = IWORD_W'(quot_int - FREQ_W'(1));
            end
            fword_next = {1'b1, div_reg[DIV_STAGES].num[FRAC_W-1:0]};
        end
    end

    // Output register; out-of-band results carry zero words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= side_reg[DIV_STAGES].status;
        if (side_reg[DIV_STAGES].status)
        begin
            code_reg  <= '0;
            odiv_reg  <= '0;
            iword_reg <= '0;
            fword_reg <= '0;
        end
        else
        begin
            code_reg  <= side_reg[DIV_STAGES].band_code;
            odiv_reg  <= side_reg[DIV_STAGES].out_div;
            iword_reg <= iword_next;
            fword_reg <= fword_next;
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign band_code         = code_reg;
    assign output_divider    = odiv_reg;
    assign pll_integer_word  = iword_reg;
    assign pll_fraction_word = fword_reg;

    // Every accepted transaction comes out after the fixed latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result strobe missing after fixed latency");

    // An out-of-band result carries all-zero words.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> band_code == '0 && output_divider == '0 &&
                           pll_integer_word == '0 && pll_fraction_word == '0)
        else $error("out-of-band result has non-zero words");

    // A valid result has a matching code and divider pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !status |->
            (band_code == BAND_CODE[BAND_DIV4]  && output_divider == BAND_ODIV[BAND_DIV4])  ||
            (band_code == BAND_CODE[BAND_DIV8]  && output_divider == BAND_ODIV[BAND_DIV8])  ||
            (band_code == BAND_CODE[BAND_DIV12] && output_divider == BAND_ODIV[BAND_DIV12]) ||
            (band_code == BAND_CODE[BAND_DIV24] && output_divider == BAND_ODIV[BAND_DIV24]))
        else $error("band code and output divider disagree");

    // The fraction lies in [2^19, 2^20) unless the PFD was zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !status |-> pll_fraction_word[FWORD_W-1] ||
                            (pll_fraction_word == '0 && pll_integer_word == IWORD_MAX))
        else $error("fraction word outside its range");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the fractional-N PLL word calculator over several crystal settings.
module tb;
    import fpwc_pkg::*;

    localparam int GAP_MAX        = 18;
    localparam int ITEMS_PER_STEP = 150;
    localparam int CRYSTAL_STEPS  = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int STOP_TIME      = 4000000;

    // One synthesiser setting as it appears on the result ports.
    typedef struct packed {
        logic                           status;
        logic [fpwc_pkg::CODE_W-1:0]    band_code;
        logic [fpwc_pkg::ODIV_W-1:0]    output_divider;
        logic [fpwc_pkg::IWORD_W-1:0]   int_word;
        logic [fpwc_pkg::FWORD_W-1:0]   frac_word;
    } pll_setting_t;

    // Works out the expected setting for each accepted request and checks the results in order.
    class pll_word_scoreboard;
        logic [fpwc_pkg::CRYSTAL_W-1:0] crystal_hz;
        pll_setting_t                   expected_settings[$];
        int unsigned                    mismatches;

        function new();
            crystal_hz = 25'd30000000;
            mismatches = 0;
        endfunction

        function void set_crystal(input logic [fpwc_pkg::CRYSTAL_W-1:0] value);
            crystal_hz = value;
        endfunction

        function int unsigned pending();
            return expected_settings.size();
        endfunction

        // Band match, phase detector frequency, then exact integer division.
        function pll_setting_t predict_setting(input logic [fpwc_pkg::FREQ_W-1:0] freq);
            pll_setting_t    s;
            longint unsigned f;
            longint unsigned xtal;
            longint unsigned pfd;
            longint unsigned q;
            longint unsigned r;
            s    = '0;
            f    = 64'(freq);
            xtal = 64'(crystal_hz);
            if (f >= 64'd850000000 && f <= 64'd1050000000)
            begin
                s.band_code      = BAND_CODE[BAND_DIV4];
                s.output_divider = BAND_ODIV[BAND_DIV4];
            end
            else if (f >= 64'd425000000 && f <= 64'd525000000)
            begin
                s.band_code      = BAND_CODE[BAND_DIV8];
                s.output_divider = BAND_ODIV[BAND_DIV8];
            end
            else if (f >= 64'd284000000 && f <= 64'd350000000)
            begin
                s.band_code      = BAND_CODE[BAND_DIV12];
                s.output_divider = BAND_ODIV[BAND_DIV12];
            end
            else if (f >= 64'd142000000 && f <= 64'd175000000)
            begin
                s.band_code      = BAND_CODE[BAND_DIV24];
                s.output_divider = BAND_ODIV[BAND_DIV24];
            end
            else
            begin
                s.status = 1'b1;
                return s;
            end
            pfd = (64'd2 * xtal) / 64'(s.output_divider);
            if (pfd == 64'd0)
            begin
                // A crystal too slow for the divider leaves nothing to divide by.
                s.int_word  = 8'd255;
                s.frac_word = '0;
            end
            else
            begin
                q = f / pfd;
                r = f % pfd;
                if (q == 64'd0)
                    s.int_word = 8'd0;
                else if (q - 64'd1 > 64'd255)
                    s.int_word = 8'd255;
                else
                    s.int_word = 8'(q - 64'd1);
                s.frac_word = 20'(64'd524288 + (r * 64'd524288) / pfd);
            end
            return s;
        endfunction

        function void note_request(input logic [fpwc_pkg::FREQ_W-1:0] freq);
            expected_settings.push_back(predict_setting(freq));
        endfunction

        function void report(input string what, input pll_setting_t want,
                             input pll_setting_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display({"%s: expected status=%0d band=%0d div=%0d int=%0d frac=%05h, ",
                          "got status=%0d band=%0d div=%0d int=%0d frac=%05h"},
                         what, want.status, want.band_code, want.output_divider,
                         want.int_word, want.frac_word, got.status, got.band_code,
                         got.output_divider, got.int_word, got.frac_word);
        endfunction

        function void check_result(input pll_setting_t got);
            pll_setting_t want;
            if (expected_settings.size() == 0)
            begin
                report("Result with no request outstanding", '0, got);
                return;
            end
            want = expected_settings.pop_front();
            if (got.status !== want.status || got.band_code !== want.band_code ||
                got.output_divider !== want.output_divider ||
                got.int_word !== want.int_word || got.frac_word !== want.frac_word)
                report("Mismatch", want, got);
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [fpwc_pkg::FREQ_W-1:0]        frequency_hz;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [fpwc_pkg::CRYSTAL_W-1:0]     cfg_data;
    logic                               done;
    logic                               status;
    logic [fpwc_pkg::CODE_W-1:0]        band_code;
    logic [fpwc_pkg::ODIV_W-1:0]        output_divider;
    logic [fpwc_pkg::IWORD_W-1:0]       pll_integer_word;
    logic [fpwc_pkg::FWORD_W-1:0]       pll_fraction_word;

    pll_word_scoreboard sb;

    fractional_pll_word_calc u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .frequency_hz      (frequency_hz),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .done              (done),
        .status            (status),
        .band_code         (band_code),
        .output_divider    (output_divider),
        .pll_integer_word  (pll_integer_word),
        .pll_fraction_word (pll_fraction_word)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(STOP_TIME);
        $display("Test completed with failures");
        $finish;
    end

    // Every result is taken at the edge that ends its cycle.
    always @(posedge clk)
    begin : result_monitor
        pll_setting_t got;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            got.status         = status;
            got.band_code      = band_code;
            got.output_divider = output_divider;
            got.int_word       = pll_integer_word;
            got.frac_word      = pll_fraction_word;
            sb.check_result(got);
        end
    end

    function automatic logic [fpwc_pkg::FREQ_W-1:0] band_lo(input int unsigned b);
        case (b)
            0:       return 31'd850000000;
            1:       return 31'd425000000;
            2:       return 31'd284000000;
            default: return 31'd142000000;
        endcase
    endfunction

    function automatic logic [fpwc_pkg::FREQ_W-1:0] band_hi(input int unsigned b);
        case (b)
            0:       return 31'd1050000000;
            1:       return 31'd525000000;
            2:       return 31'd350000000;
            default: return 31'd175000000;
        endcase
    endfunction

    // Mostly in-band frequencies, with band edges, near misses and the full input range.
    function automatic logic [fpwc_pkg::FREQ_W-1:0] random_frequency();
        int unsigned pick;
        int unsigned b;
        pick = $urandom_range(0, 9);
        b    = $urandom_range(0, 3);
        if (pick <= 5)
            return fpwc_pkg::FREQ_W'(32'(band_lo(b)) +
                                     $urandom_range(0, 32'(band_hi(b) - band_lo(b))));
        else if (pick == 6)
        begin
            case ($urandom_range(0, 3))
                0:       return band_lo(b) - 31'd1;
                1:       return band_lo(b);
                2:       return band_hi(b);
                default: return band_hi(b) + 31'd1;
            endcase
        end
        else if (pick == 7)
            return fpwc_pkg::FREQ_W'($urandom_range(0, 1100000000));
        else
            return fpwc_pkg::FREQ_W'($urandom);
    endfunction

    // Crystal settings: limits of the range, the full register width and degenerate values.
    function automatic logic [fpwc_pkg::CRYSTAL_W-1:0] crystal_for_step(input int unsigned step);
        case (step)
            1:       return 25'd25000000;
            2:       return 25'd32000000;
            3:       return 25'h1FFFFFF;
            4:       return 25'd0;
            5:       return 25'd1;
            6:       return 25'd5;
            7:       return 25'd3000000;
            8:       return fpwc_pkg::CRYSTAL_W'($urandom_range(25000000, 32000000));
            9:       return fpwc_pkg::CRYSTAL_W'($urandom);
            default: return 25'd30000000;
        endcase
    endfunction

    // One request transaction, preceded by the given number of idle cycles.
    task automatic send_request(input logic [fpwc_pkg::FREQ_W-1:0] freq,
                                input int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        frequency_hz <= freq;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(freq);
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic settle(input int unsigned extra);
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_crystal(input logic [fpwc_pkg::CRYSTAL_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_crystal(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random requests in stretches with and without idle cycles.
    task automatic run_requests(input int unsigned count);
        int unsigned stretch_left;
        bit          no_idle;
        stretch_left = 0;
        no_idle      = 1'b0;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(10, 60);
                no_idle      = ($urandom_range(0, 2) == 0);
            end
            stretch_left--;
            if ($urandom_range(0, 149) == 0)
                settle(0);
            send_request(random_frequency(), no_idle ? 0 : $urandom_range(0, GAP_MAX));
        end
    endtask

    // Reset, directed requests, then random requests under each crystal setting.
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        frequency_hz = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Field extremes, alternating bit patterns and both sides of every band edge.
        send_request(31'd0, 0);
        send_request(31'h7FFFFFFF, 0);
        send_request(31'h2AAAAAAA, 1);
        send_request(31'h55555555, 0);
        for (int unsigned b = 0; b < 4; b++)
        begin
            send_request(band_lo(b) - 31'd1, 0);
            send_request(band_lo(b), 0);
            send_request(band_hi(b), 2);
            send_request(band_hi(b) + 31'd1, 0);
        end
        run_requests(ITEMS_PER_STEP);

        for (int unsigned step = 1; step < CRYSTAL_STEPS; step++)
        begin
            settle(fpwc_pkg::LATENCY);
            write_crystal(crystal_for_step(step));
            run_requests(ITEMS_PER_STEP);
        end

        settle(fpwc_pkg::LATENCY + 4);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
